// ----- sv/qrs_pkg.sv -----
`timescale 1ns / 1ps
package qrs_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COEF_W = 32;
	localparam int DISC_W = 66;
	// The square root of a discriminant below 2^66 fits in 33 bits; one spare bit.
	localparam int ROOT_W = 34;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int DIVR_W = COEF_W + 1;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_A_ZERO = 2'd1,
		STAT_SAT    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CNT_NONE = 2'd0,
		CNT_ONE  = 2'd1,
		CNT_TWO  = 2'd2
	} cnt_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b;
		logic [COEF_W-1:0]        ua;
		logic                     a_neg;
		logic                     a_zero;
		cnt_t                     cnt;
	} sq_side_t;

	typedef struct packed {
		logic a_zero;
		cnt_t cnt;
		logic neg_p;
		logic neg_m;
	} div_side_t;

endpackage

// ----- sv/qrs_sqrt_cell.sv -----
`timescale 1ns / 1ps
module qrs_sqrt_cell import qrs_pkg::*; #(
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  logic [RAD_W-1:0]  rad_in,
	input  logic [REM_W-1:0]  rem_in,
	input  logic [ROOT_W-1:0] root_in,
	input  logic [SW-1:0]     side_in,
	output logic              vld_out,
	output logic [RAD_W-1:0]  rad_out,
	output logic [REM_W-1:0]  rem_out,
	output logic [ROOT_W-1:0] root_out,
	output logic [SW-1:0]     side_out
);

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             ge;

	// One result bit per cell: bring down two radicand bits, try root*4+1.
	always_comb begin
		rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		trial  = {root_in, 2'b01};
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_out  <= {rad_in[RAD_W-3:0], 2'b00};
		rem_out  <= ge ? (rem_sh - trial) : rem_sh;
		root_out <= {root_in[ROOT_W-2:0], ge};
		side_out <= side_in;
	end

endmodule

// ----- sv/qrs_div_cell.sv -----
`timescale 1ns / 1ps
module qrs_div_cell import qrs_pkg::*; #(
	parameter int NW = 50,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  logic [DIVR_W-1:0] divr_in,
	input  logic [NW-1:0]     num_p_in,
	input  logic [NW-1:0]     num_m_in,
	input  logic [DIVR_W-1:0] rem_p_in,
	input  logic [DIVR_W-1:0] rem_m_in,
	input  logic [NW-1:0]     quo_p_in,
	input  logic [NW-1:0]     quo_m_in,
	input  logic [SW-1:0]     side_in,
	output logic              vld_out,
	output logic [DIVR_W-1:0] divr_out,
	output logic [NW-1:0]     num_p_out,
	output logic [NW-1:0]     num_m_out,
	output logic [DIVR_W-1:0] rem_p_out,
	output logic [DIVR_W-1:0] rem_m_out,
	output logic [NW-1:0]     quo_p_out,
	output logic [NW-1:0]     quo_m_out,
	output logic [SW-1:0]     side_out
);

	logic [DIVR_W:0] sh_p, sh_m, dv;
	logic            ge_p, ge_m;
	logic [DIVR_W:0] df_p, df_m;

	// Restoring division, one quotient bit per cell for each of the two roots.
	always_comb begin
		dv   = {1'b0, divr_in};
		sh_p = {rem_p_in, num_p_in[NW-1]};
		sh_m = {rem_m_in, num_m_in[NW-1]};
		ge_p = (sh_p >= dv);
		ge_m = (sh_m >= dv);
		df_p = ge_p ? (sh_p - dv) : sh_p;
		df_m = ge_m ? (sh_m - dv) : sh_m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		divr_out  <= divr_in;
		num_p_out <= {num_p_in[NW-2:0], 1'b0};
		num_m_out <= {num_m_in[NW-2:0], 1'b0};
		rem_p_out <= df_p[DIVR_W-1:0];
		rem_m_out <= df_m[DIVR_W-1:0];
		quo_p_out <= {quo_p_in[NW-2:0], ge_p};
		quo_m_out <= {quo_m_in[NW-2:0], ge_m};
		side_out  <= side_in;
	end

endmodule

// ----- sv/quadratic_root_solver_core.sv -----
`timescale 1ns / 1ps
// Real roots of A*t^2 + B*t + C for signed fixed point coefficients with
// FRAC_BITS fraction bits (Q16.16 by default). A request is taken on a clock
// edge where start is high and busy is low; busy is never raised, so a new
// request may be given in every cycle and many are in flight at once.
// Each request yields one result, shown for a single cycle with done high:
// root_count, root_plus, root_minus, nearest_root and status. Results leave
// in request order and the receiver cannot hold them off.
// The pipe holds three registers for the magnitudes, products and
// discriminant, 34 square root cells at one result bit each, one register to
// form the numerators, 34 + FRAC_BITS divider cells at one quotient bit each,
// and two registers for saturation and selection.
// Throughput is one request per cycle.
// Reset clears every valid flag in the pipe, so requests in flight are lost
// and no done pulse follows reset until a new request is accepted.
module quadratic_root_solver_core import qrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [COEF_W-1:0] coef_a,
	input  logic signed [COEF_W-1:0] coef_b,
	input  logic signed [COEF_W-1:0] coef_c,
	output logic                     done,
	output logic [1:0]               root_count,
	output logic signed [COEF_W-1:0] root_plus,
	output logic signed [COEF_W-1:0] root_minus,
	output logic signed [COEF_W-1:0] nearest_root,
	output logic [1:0]               status
);

	localparam int NW = ROOT_W + FRAC_BITS;
	localparam int SQ_SW = $bits(sq_side_t);
	localparam int DV_SW = $bits(div_side_t);
	localparam logic [COEF_W-1:0] MINUS_ONE = ~((COEF_W'(1) << FRAC_BITS) - COEF_W'(1));

	assign busy = 1'b0;

	// Stage 1: magnitudes and signs.
	logic                     vld_s1;
	logic [COEF_W-1:0]        ua_s1, ub_s1, uc_s1;
	logic                     a_neg_s1, c_neg_s1, a_zero_s1;
	logic signed [COEF_W-1:0] b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ua_s1     <= coef_a[COEF_W-1] ? (~coef_a + 1'b1) : coef_a;
		ub_s1     <= coef_b[COEF_W-1] ? (~coef_b + 1'b1) : coef_b;
		uc_s1     <= coef_c[COEF_W-1] ? (~coef_c + 1'b1) : coef_c;
		a_neg_s1  <= coef_a[COEF_W-1];
		c_neg_s1  <= coef_c[COEF_W-1];
		a_zero_s1 <= (coef_a == '0);
		b_s1      <= coef_b;
	end

	// Stage 2: B*B and |A*C|.
	logic                     vld_s2;
	logic [2*COEF_W-1:0]      bsq_s2, p_s2;
	logic [COEF_W-1:0]        ua_s2;
	logic                     a_neg_s2, c_neg_s2, a_zero_s2;
	logic signed [COEF_W-1:0] b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		bsq_s2    <= ub_s1 * ub_s1;
		p_s2      <= ua_s1 * uc_s1;
		ua_s2     <= ua_s1;
		a_neg_s2  <= a_neg_s1;
		c_neg_s2  <= c_neg_s1;
		a_zero_s2 <= a_zero_s1;
		b_s2      <= b_s1;
	end

	// Stage 3: discriminant as a magnitude, and the number of roots.
	logic              vld_s3;
	logic [DISC_W-1:0] d_s3;
	sq_side_t          sd_s3;
	logic              ac_pos;
	logic [DISC_W-1:0] q4, bsq_w, d_nx;
	cnt_t              cnt_nx;

	always_comb begin
		ac_pos = (p_s2 != '0) && (a_neg_s2 == c_neg_s2);
		q4     = {p_s2, 2'b00};
		bsq_w  = {2'b00, bsq_s2};
		if (!ac_pos) begin
			d_nx   = bsq_w + q4;
			cnt_nx = (d_nx == '0) ? CNT_ONE : CNT_TWO;
		end else if (q4 <= bsq_w) begin
			d_nx   = bsq_w - q4;
			cnt_nx = (d_nx == '0) ? CNT_ONE : CNT_TWO;
		end else begin
			d_nx   = '0;
			cnt_nx = CNT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		d_s3         <= d_nx;
		sd_s3.b      <= b_s2;
		sd_s3.ua     <= ua_s2;
		sd_s3.a_neg  <= a_neg_s2;
		sd_s3.a_zero <= a_zero_s2;
		sd_s3.cnt    <= cnt_nx;
	end

	// Square root row.
	logic              sq_vld  [ROOT_W+1];
	logic [RAD_W-1:0]  sq_rad  [ROOT_W+1];
	logic [REM_W-1:0]  sq_rem  [ROOT_W+1];
	logic [ROOT_W-1:0] sq_root [ROOT_W+1];
	logic [SQ_SW-1:0]  sq_side [ROOT_W+1];

	assign sq_vld[0]  = vld_s3;
	assign sq_rad[0]  = {{(RAD_W-DISC_W){1'b0}}, d_s3};
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = sd_s3;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		qrs_sqrt_cell #(.SW(SQ_SW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_in   (sq_vld[i]),
			.rad_in   (sq_rad[i]),
			.rem_in   (sq_rem[i]),
			.root_in  (sq_root[i]),
			.side_in  (sq_side[i]),
			.vld_out  (sq_vld[i+1]),
			.rad_out  (sq_rad[i+1]),
			.rem_out  (sq_rem[i+1]),
			.root_out (sq_root[i+1]),
			.side_out (sq_side[i+1])
		);
	end

	// Stage 4: numerators -B +/- sqrt(D), scaled, and the divisor 2|A|.
	sq_side_t           sq_o;
	logic signed [35:0] nb, sx, n_p, n_m;
	logic [35:0]        an_p, an_m;
	logic               vld_s4;
	logic [NW-1:0]      num_p_s4, num_m_s4;
	logic [DIVR_W-1:0]  divr_s4;
	div_side_t          dsd_s4;

	always_comb begin
		sq_o = sq_side[ROOT_W];
		nb   = -(36'(sq_o.b));
		sx   = {2'b00, sq_root[ROOT_W]};
		n_p  = nb + sx;
		n_m  = nb - sx;
		an_p = n_p[35] ? (~n_p + 1'b1) : n_p;
		an_m = n_m[35] ? (~n_m + 1'b1) : n_m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		num_p_s4      <= {an_p[ROOT_W-1:0], {FRAC_BITS{1'b0}}};
		num_m_s4      <= {an_m[ROOT_W-1:0], {FRAC_BITS{1'b0}}};
		divr_s4       <= {sq_o.ua, 1'b0};
		dsd_s4.a_zero <= sq_o.a_zero;
		dsd_s4.cnt    <= sq_o.cnt;
		dsd_s4.neg_p  <= n_p[35] ^ sq_o.a_neg;
		dsd_s4.neg_m  <= n_m[35] ^ sq_o.a_neg;
	end

	// Divider row, both roots side by side.
	logic              dv_vld   [NW+1];
	logic [DIVR_W-1:0] dv_divr  [NW+1];
	logic [NW-1:0]     dv_num_p [NW+1];
	logic [NW-1:0]     dv_num_m [NW+1];
	logic [DIVR_W-1:0] dv_rem_p [NW+1];
	logic [DIVR_W-1:0] dv_rem_m [NW+1];
	logic [NW-1:0]     dv_quo_p [NW+1];
	logic [NW-1:0]     dv_quo_m [NW+1];
	logic [DV_SW-1:0]  dv_side  [NW+1];

	assign dv_vld[0]   = vld_s4;
	assign dv_divr[0]  = divr_s4;
	assign dv_num_p[0] = num_p_s4;
	assign dv_num_m[0] = num_m_s4;
	assign dv_rem_p[0] = '0;
	assign dv_rem_m[0] = '0;
	assign dv_quo_p[0] = '0;
	assign dv_quo_m[0] = '0;
	assign dv_side[0]  = dsd_s4;

	for (genvar j = 0; j < NW; j++) begin : g_div
		qrs_div_cell #(.NW(NW), .SW(DV_SW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.vld_in    (dv_vld[j]),
			.divr_in   (dv_divr[j]),
			.num_p_in  (dv_num_p[j]),
			.num_m_in  (dv_num_m[j]),
			.rem_p_in  (dv_rem_p[j]),
			.rem_m_in  (dv_rem_m[j]),
			.quo_p_in  (dv_quo_p[j]),
			.quo_m_in  (dv_quo_m[j]),
			.side_in   (dv_side[j]),
			.vld_out   (dv_vld[j+1]),
			.divr_out  (dv_divr[j+1]),
			.num_p_out (dv_num_p[j+1]),
			.num_m_out (dv_num_m[j+1]),
			.rem_p_out (dv_rem_p[j+1]),
			.rem_m_out (dv_rem_m[j+1]),
			.quo_p_out (dv_quo_p[j+1]),
			.quo_m_out (dv_quo_m[j+1]),
			.side_out  (dv_side[j+1])
		);
	end

	// Stage 5: sign and saturation of each root.
	div_side_t                dv_o;
	logic [NW-1:0]            qp, qm;
	logic                     en_p, en_m, sat_p, sat_m;
	logic signed [COEF_W-1:0] rp_nx, rm_nx;
	logic                     vld_s5, sat_s5, a_zero_s5;
	cnt_t                     cnt_s5;
	logic signed [COEF_W-1:0] rp_s5, rm_s5;

	always_comb begin
		dv_o  = dv_side[NW];
		qp    = dv_quo_p[NW];
		qm    = dv_quo_m[NW];
		en_p  = !dv_o.a_zero && (dv_o.cnt != CNT_NONE);
		en_m  = !dv_o.a_zero && (dv_o.cnt == CNT_TWO);
		sat_p = 1'b0;
		sat_m = 1'b0;
		rp_nx = '0;
		rm_nx = '0;
		if (en_p) begin
			if (dv_o.neg_p) begin
				sat_p = (qp[NW-1:COEF_W] != '0) || (qp[COEF_W-1] && qp[COEF_W-2:0] != '0);
				rp_nx = sat_p ? {1'b1, {(COEF_W-1){1'b0}}} : -qp[COEF_W-1:0];
			end else begin
				sat_p = (qp[NW-1:COEF_W-1] != '0);
				rp_nx = sat_p ? {1'b0, {(COEF_W-1){1'b1}}} : qp[COEF_W-1:0];
			end
		end
		if (en_m) begin
			if (dv_o.neg_m) begin
				sat_m = (qm[NW-1:COEF_W] != '0) || (qm[COEF_W-1] && qm[COEF_W-2:0] != '0);
				rm_nx = sat_m ? {1'b1, {(COEF_W-1){1'b0}}} : -qm[COEF_W-1:0];
			end else begin
				sat_m = (qm[NW-1:COEF_W-1] != '0);
				rm_nx = sat_m ? {1'b0, {(COEF_W-1){1'b1}}} : qm[COEF_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= dv_vld[NW];
		end
	end

	always_ff @(posedge clk) begin
		rp_s5     <= rp_nx;
		rm_s5     <= rm_nx;
		sat_s5    <= sat_p || sat_m;
		a_zero_s5 <= dv_o.a_zero;
		cnt_s5    <= dv_o.cnt;
	end

	// Stage 6: nearest root, status and the result registers.
	logic signed [COEF_W-1:0] near_nx;
	status_t                  stat_nx;

	always_comb begin
		case (cnt_s5)
			CNT_NONE: near_nx = MINUS_ONE;
			CNT_ONE:  near_nx = rp_s5;
			default:  near_nx = (rm_s5 < rp_s5) ? rm_s5 : rp_s5;
		endcase
		if (a_zero_s5) begin
			stat_nx = STAT_A_ZERO;
		end else if (sat_s5) begin
			stat_nx = STAT_SAT;
		end else begin
			stat_nx = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		root_count   <= cnt_s5;
		root_plus    <= rp_s5;
		root_minus   <= rm_s5;
		nearest_root <= near_nx;
		status       <= stat_nx;
	end

endmodule

// ----- sv/qrs_checker.sv -----
`timescale 1ns / 1ps
module qrs_checker import qrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic signed [COEF_W-1:0] coef_a,
	input logic signed [COEF_W-1:0] coef_b,
	input logic signed [COEF_W-1:0] coef_c,
	input logic                     done,
	input logic [1:0]               root_count,
	input logic signed [COEF_W-1:0] root_plus,
	input logic signed [COEF_W-1:0] root_minus,
	input logic signed [COEF_W-1:0] nearest_root,
	input logic [1:0]               status
);

	localparam logic [COEF_W-1:0] MINUS_ONE = ~((COEF_W'(1) << FRAC_BITS) - COEF_W'(1));

	// The block never refuses a request.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");

	// With no real root both roots are zero and the nearest root is minus one.
	a_no_root: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_count == CNT_NONE |->
		root_plus == '0 && root_minus == '0 && nearest_root == MINUS_ONE)
		else $error("wrong result for no real root");

	// A double root leaves the minus-sign root at zero and is itself the nearest.
	a_one_root: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_count == CNT_ONE |-> root_minus == '0 && nearest_root == root_plus)
		else $error("wrong result for a double root");

	// With A zero no root value is reported.
	a_a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_A_ZERO |-> root_plus == '0 && root_minus == '0)
		else $error("roots reported with A zero");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> root_count != 2'd3 && status != 2'd3)
		else $error("count or status out of range");

endmodule

bind quadratic_root_solver_core qrs_checker #(.FRAC_BITS(FRAC_BITS)) u_qrs_checker (.*);

// ----- tb/tb_quadratic_root_solver_core.sv -----
`timescale 1ns / 1ps
module tb_quadratic_root_solver_core;
	import qrs_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FB;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 120;

	typedef struct packed {
		logic [1:0]  cnt;
		logic [31:0] rp;
		logic [31:0] rm;
		logic [31:0] nr;
		logic [1:0]  st;
	} roots_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [COEF_W-1:0] coef_a = '0;
	logic signed [COEF_W-1:0] coef_b = '0;
	logic signed [COEF_W-1:0] coef_c = '0;
	logic done;
	logic [1:0] root_count;
	logic signed [COEF_W-1:0] root_plus;
	logic signed [COEF_W-1:0] root_minus;
	logic signed [COEF_W-1:0] nearest_root;
	logic [1:0] status;

	roots_t expected_roots[$];
	int error_count = 0;
	int idle_cycles = 0;

	quadratic_root_solver_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.done(done), .root_count(root_count), .root_plus(root_plus),
		.root_minus(root_minus), .nearest_root(nearest_root), .status(status)
	);

	always #1 clk = ~clk;

	function automatic longint divide_root(longint n, longint a, ref bit sat);
		bit neg;
		longint un, ua, q;
		neg = (n < 0) != (a < 0);
		un = (n < 0) ? -n : n;
		ua = (a < 0) ? -a : a;
		q = (un << FB) / (ua * 2);
		if (neg) begin
			if (q > 64'h8000_0000) begin
				sat = 1'b1;
				return -64'sh8000_0000;
			end
			return -q;
		end
		if (q > 64'h7FFF_FFFF) begin
			sat = 1'b1;
			return 64'sh7FFF_FFFF;
		end
		return q;
	endfunction

	function automatic roots_t solve_roots(longint a, longint b, longint c);
		roots_t r;
		logic signed [67:0] disc;
		logic [67:0] sq;
		logic [33:0] s, cand;
		longint rp, rm, nr;
		bit sat;
		cnt_t cnt;
		status_t st;
		rp = 0;
		rm = 0;
		sat = 1'b0;
		st = STAT_OK;
		s = '0;
		disc = 68'(b * b) - 4 * 68'(a * c);
		cnt = (disc < 0) ? CNT_NONE : (disc == 0) ? CNT_ONE : CNT_TWO;
		if (a == 0) begin
			st = STAT_A_ZERO;
		end else if (cnt != CNT_NONE) begin
			for (int i = 33; i >= 0; i--) begin
				cand = s | (34'd1 << i);
				sq = {34'd0, cand} * {34'd0, cand};
				if (sq <= disc) s = cand;
			end
			rp = divide_root(-b + longint'(s), a, sat);
			if (cnt == CNT_TWO) rm = divide_root(-b - longint'(s), a, sat);
			if (sat) st = STAT_SAT;
		end
		if (cnt == CNT_NONE) nr = -ONE;
		else if (cnt == CNT_ONE) nr = rp;
		else nr = (rm < rp) ? rm : rp;
		r.cnt = cnt;
		r.rp = rp[31:0];
		r.rm = rm[31:0];
		r.nr = nr[31:0];
		r.st = st;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Requests are judged at the falling edge, away from the driving edge.
	always @(negedge clk) begin
		roots_t w;
		if (arst_n && start && !busy) begin
			expected_roots = {expected_roots, solve_roots(longint'(coef_a),
				longint'(coef_b), longint'(coef_c))};
		end
		if (arst_n && done) begin
			if (expected_roots.size() == 0) begin
				report_mismatch("unexpected result", 32'(done), 32'd0);
			end else begin
				w = expected_roots.pop_front();
				if (root_count !== w.cnt) report_mismatch("root_count", root_count, w.cnt);
				if (root_plus !== w.rp) report_mismatch("root_plus", root_plus, w.rp);
				if (root_minus !== w.rm) report_mismatch("root_minus", root_minus, w.rm);
				if (nearest_root !== w.nr) report_mismatch("nearest_root", nearest_root, w.nr);
				if (status !== w.st) report_mismatch("status", status, w.st);
			end
		end
		if (arst_n && !(start && !busy) && !done) idle_cycles++;
		else idle_cycles = 0;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int random_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Drives one request and, once it has been taken, holds start low for the gap, if any, before returning.
	task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c, int gap);
		start <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		forever begin
			@(negedge clk);
			if (!busy) break;
			@(posedge clk);
		end
		@(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The sender stops first, so no further request enters while draining.
	task automatic wait_for_drain();
		start <= 1'b0;
		while (expected_roots.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_coefs(32'(ONE), 32'(-3 * ONE), 32'(2 * ONE), 0);
		send_coefs(32'(ONE), 32'(2 * ONE), 32'(ONE), 0);
		send_coefs(32'(ONE), 32'(0), 32'(ONE), 1);
		send_coefs(32'(0), 32'(ONE), 32'(ONE), 0);
		send_coefs(32'(0), 32'(0), 32'(0), 0);
		send_coefs(32'(0), 32'(0), 32'(ONE), 2);
		send_coefs(32'(0), 32'h8000_0000, 32'h8000_0000, 0);
		send_coefs(32'(-ONE), 32'(ONE), 32'(6 * ONE), 0);
		send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3);
		send_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
		send_coefs(32'd1, 32'h7FFF_FFFF, 32'd0, 0);
		send_coefs(32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 0);
		send_coefs(32'd1, 32'h8000_0000, 32'h8000_0000, 0);
		send_coefs(32'(ONE), 32'd0, 32'd0, 0);
		send_coefs(32'd1, 32'd2, 32'd1, 0);
		send_coefs(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 0);
		send_coefs(32'h8000_0000, 32'd0, 32'h8000_0000, 5);
		send_coefs(32'd3, 32'hFFFF_FFFF, 32'h8000_0000, 0);
	endtask

	task automatic test_random(int n);
		int kind, ka, kk;
		logic [31:0] a, b, c;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			a = $urandom();
			b = $urandom();
			c = $urandom();
			if (kind < 3) begin
				// Moderate coefficients, well inside the Q16.16 range.
				a = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
				b = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
				c = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
			end else if (kind < 5) begin
				// Perfect square: a double root at -k.
				ka = $signed($urandom_range(0, 512)) - 256;
				kk = $signed($urandom_range(0, 512)) - 256;
				a = 32'(ka);
				b = 32'(2 * ka * kk);
				c = 32'(ka * kk * kk);
			end else if (kind == 5) begin
				a = 32'd0;
			end else if (kind == 6) begin
				c = 32'd0;
			end
			send_coefs(a, b, c, random_gap());
			if (i == n / 2) wait_for_drain();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(450);
		start <= 1'b0;
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/qrs_pkg.sv
sv/qrs_sqrt_cell.sv
sv/qrs_div_cell.sv
sv/quadratic_root_solver_core.sv
sv/qrs_checker.sv
tb/tb_quadratic_root_solver_core.sv
